// ----- rtl/stj_pkg.sv -----
// stj_pkg: shared types, constants and the sequencer microcode for speed_to_joystick_code
// no dependencies; imported by the top level
package stj_pkg;

    // fixed point formats
    localparam int SPEED_FRAC_BITS = 12;  // fraction bits of speed and yaw inputs
    localparam int COEF_FRAC_BITS  = 12;  // fraction bits of coefficients and accumulator
    localparam int IN_W            = 16;
    localparam int ACC_W           = 32;
    localparam int PROD_W          = ACC_W + IN_W;
    localparam int CMP_W           = 24;  // truncated value and clamp limits compare here

    localparam int ONE = 1 << SPEED_FRAC_BITS;

    // thresholds, compared as scaled integers
    localparam logic signed [31:0] FWD_HI_LIM = 32'(33 * ONE);   // 100*s > this
    localparam logic signed [31:0] FWD_LO_LIM = -32'(2 * ONE);   // 10*s < this
    localparam logic signed [31:0] TRN_HI_LIM = -32'(17 * ONE);  // 10*r < this

    // cubic coefficients, Q.12, rounded to nearest
    localparam logic signed [ACC_W-1:0] FWD_C3 = -32'sd58232832;
    localparam logic signed [ACC_W-1:0] FWD_C2 = -32'sd7682048;
    localparam logic signed [ACC_W-1:0] FWD_C1 = 32'sd23151411;
    localparam logic signed [ACC_W-1:0] FWD_C0 = 32'sd7981875;
    localparam logic signed [ACC_W-1:0] TRN_C3 = 32'sd751370;
    localparam logic signed [ACC_W-1:0] TRN_C2 = -32'sd78471;
    localparam logic signed [ACC_W-1:0] TRN_C1 = -32'sd4700160;
    localparam logic signed [ACC_W-1:0] TRN_C0 = 32'sd8272282;

    // configuration register indexes
    localparam logic [1:0] REG_CODE_HIGH       = 2'd0;
    localparam logic [1:0] REG_CODE_LOW        = 2'd1;
    localparam logic [1:0] REG_FORWARD_NEUTRAL = 2'd2;
    localparam logic [1:0] REG_TURN_NEUTRAL    = 2'd3;

    // lanes of the shared datapath
    localparam logic LANE_FWD = 1'b0;
    localparam logic LANE_TRN = 1'b1;

    // coefficient selects for the add step
    localparam logic [1:0] COEF_C2   = 2'd0;
    localparam logic [1:0] COEF_C1   = 2'd1;
    localparam logic [1:0] COEF_C0   = 2'd2;
    localparam logic [1:0] COEF_NONE = 2'd3;

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_FIN = 3'd7;

    typedef struct packed {
        logic              mul_en;     // product register takes acc * operand
        logic              mul_lane;
        logic              add_en;     // accumulator takes floor(prod / 2^F) + coef
        logic              add_lane;
        logic [1:0]        coef_sel;
        logic              fin;        // truncate, clamp and present result
        logic              skip_jmp;   // jump when neither lane needs its cubic
        logic [STEP_W-1:0] jmp_target;
    } ucode_t;

    function automatic logic signed [ACC_W-1:0] coef_lookup(input logic lane,
                                                             input logic [1:0] sel);
        logic signed [ACC_W-1:0] c;
        c = '0;
        case ({lane, sel})
            {LANE_FWD, COEF_C2}: c = FWD_C2;
            {LANE_FWD, COEF_C1}: c = FWD_C1;
            {LANE_FWD, COEF_C0}: c = FWD_C0;
            {LANE_TRN, COEF_C2}: c = TRN_C2;
            {LANE_TRN, COEF_C1}: c = TRN_C1;
            {LANE_TRN, COEF_C0}: c = TRN_C0;
            default:             c = '0;
        endcase
        return c;
    endfunction

    // two interleaved horner cubics on one multiplier and one adder
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '0;
        case (step)
            3'd0: w = '{1'b1, LANE_FWD, 1'b0, LANE_FWD, COEF_NONE, 1'b0, 1'b1, STEP_FIN};
            3'd1: w = '{1'b1, LANE_TRN, 1'b1, LANE_FWD, COEF_C2,   1'b0, 1'b0, 3'd0};
            3'd2: w = '{1'b1, LANE_FWD, 1'b1, LANE_TRN, COEF_C2,   1'b0, 1'b0, 3'd0};
            3'd3: w = '{1'b1, LANE_TRN, 1'b1, LANE_FWD, COEF_C1,   1'b0, 1'b0, 3'd0};
            3'd4: w = '{1'b1, LANE_FWD, 1'b1, LANE_TRN, COEF_C1,   1'b0, 1'b0, 3'd0};
            3'd5: w = '{1'b1, LANE_TRN, 1'b1, LANE_FWD, COEF_C0,   1'b0, 1'b0, 3'd0};
            3'd6: w = '{1'b0, LANE_FWD, 1'b1, LANE_TRN, COEF_C0,   1'b0, 1'b0, 3'd0};
            3'd7: w = '{1'b0, LANE_FWD, 1'b0, LANE_FWD, COEF_NONE, 1'b1, 1'b0, 3'd0};
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/speed_to_joystick_code.sv -----
// speed_to_joystick_code: maps forward speed and yaw rate to two joystick voltage codes
// depends on stj_pkg (formats, coefficients, microcode rom)
//
// usage
//   input channel : forward_speed, yaw_rate (signed q3.12) with in_valid / in_stall;
//                   a beat moves when in_valid is high and in_stall is low
//   output channel: forward_code, turn_code with out_valid / out_stall, same rule
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
//                   always high, write only while the block is idle
//   an input beat equal to the previous one (after the first since reset) is taken
//   and dropped with no result
//   a new input runs an 8-step microprogram: the two horner cubics share one
//   multiplier and one adder, interleaved, and the result is registered at the last
//   step; in_stall stays high after the input beat until that last step writes the
//   output register, so no new input is taken meanwhile; when both inputs take a
//   fixed code the program jumps straight from its first step to its last step
//   the result sits in an output register; a stalled receiver holds it there and the
//   block still takes the next input, but the last step waits until that register
//   is free
//   reset: configuration and control registers back to their defaults, no result pending, no item seen
module speed_to_joystick_code #(
    parameter int CODE_WIDTH = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [15:0]    forward_speed,
    input  logic signed [15:0]    yaw_rate,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CODE_WIDTH-1:0] forward_code,
    output logic [CODE_WIDTH-1:0] turn_code,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CODE_WIDTH-1:0] cfg_data
);
    import stj_pkg::*;

    // configuration registers
    logic [CODE_WIDTH-1:0] code_high_reg, code_low_reg;
    logic [CODE_WIDTH-1:0] fwd_neutral_reg, trn_neutral_reg;

    // sequencer control
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              seen_reg, seen_next;
    logic              out_valid_reg, out_valid_next;

    // datapath
    logic signed [IN_W-1:0]   fwd_reg, fwd_next;   // doubles as the last forward seen
    logic signed [IN_W-1:0]   yaw_reg, yaw_next;   // doubles as the last yaw seen
    logic signed [ACC_W-1:0]  acc_f_reg, acc_f_next;
    logic signed [ACC_W-1:0]  acc_t_reg, acc_t_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [CODE_WIDTH-1:0]    fcode_reg, fcode_next;
    logic [CODE_WIDTH-1:0]    tcode_reg, tcode_next;

    ucode_t ucw;

    logic in_fire, same_item, start;
    logic fin_fire;

    logic signed [31:0] s_ext, r_ext;
    logic fwd_hi, fwd_lo, fwd_zero, trn_hi, trn_zero;
    logic fwd_fixed, trn_fixed;

    logic signed [ACC_W-1:0]  mul_a;
    logic signed [IN_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod_shift;
    logic signed [ACC_W-1:0]  add_res;

    logic [CODE_WIDTH-1:0] fwd_cubic_code, trn_cubic_code;

    // truncate a q.12 accumulator toward zero, then clamp high first, low second
    function automatic logic [CODE_WIDTH-1:0] clamp_code(
        input logic signed [ACC_W-1:0] acc,
        input logic [CODE_WIDTH-1:0]   hi,
        input logic [CODE_WIDTH-1:0]   lo
    );
        logic signed [ACC_W-1:0] adj;
        logic signed [ACC_W-1:0] val;
        logic signed [CMP_W-1:0] v;
        logic signed [CMP_W-1:0] hi_s, lo_s;
        adj  = acc + (acc[ACC_W-1] ? ACC_W'((1 << COEF_FRAC_BITS) - 1) : '0);
        val  = adj >>> COEF_FRAC_BITS;
        v    = val[CMP_W-1:0];
        hi_s = $signed({{(CMP_W-CODE_WIDTH){1'b0}}, hi});
        lo_s = $signed({{(CMP_W-CODE_WIDTH){1'b0}}, lo});
        if (v > hi_s)
            return hi;
        else if (v < lo_s)
            return lo;
        else
            return v[CODE_WIDTH-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall  = busy_reg;
    assign out_valid = out_valid_reg;
    assign forward_code = fcode_reg;
    assign turn_code    = tcode_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_high_reg   <= CODE_WIDTH'(2800);
            code_low_reg    <= CODE_WIDTH'(850);
            fwd_neutral_reg <= CODE_WIDTH'(1987);
            trn_neutral_reg <= CODE_WIDTH'(1994);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CODE_HIGH:       code_high_reg   <= cfg_data;
                REG_CODE_LOW:        code_low_reg    <= cfg_data;
                REG_FORWARD_NEUTRAL: fwd_neutral_reg <= cfg_data;
                REG_TURN_NEUTRAL:    trn_neutral_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // special ranges of the latched inputs
    always_comb
    begin
        s_ext     = 32'(fwd_reg);
        r_ext     = 32'(yaw_reg);
        fwd_hi    = (s_ext * 32'sd100) > FWD_HI_LIM;
        fwd_lo    = (s_ext * 32'sd10) < FWD_LO_LIM;
        fwd_zero  = (fwd_reg == '0);
        trn_hi    = (r_ext * 32'sd10) < TRN_HI_LIM;
        trn_zero  = (yaw_reg == '0);
        fwd_fixed = fwd_hi || fwd_lo || fwd_zero;
        trn_fixed = trn_hi || trn_zero;
    end

    assign ucw = ucode_rom(step_reg);

    // shared multiply and add
    always_comb
    begin
        mul_a      = (ucw.mul_lane == LANE_TRN) ? acc_t_reg : acc_f_reg;
        mul_b      = (ucw.mul_lane == LANE_TRN) ? yaw_reg : fwd_reg;
        prod_shift = prod_reg >>> SPEED_FRAC_BITS;
        add_res    = $signed(prod_shift[ACC_W-1:0])
                   + coef_lookup(ucw.add_lane, ucw.coef_sel);
    end

    assign fwd_cubic_code = clamp_code(acc_f_reg, code_high_reg, code_low_reg);
    assign trn_cubic_code = clamp_code(acc_t_reg, code_high_reg, code_low_reg);

    always_comb
    begin
        in_fire   = in_valid && !in_stall;
        same_item = seen_reg && (forward_speed == fwd_reg) && (yaw_rate == yaw_reg);
        start     = in_fire && !same_item;
        // last step may only write the output register once it is free
        fin_fire  = busy_reg && ucw.fin && (!out_valid_reg || !out_stall);

        busy_next      = busy_reg;
        step_next      = step_reg;
        seen_next      = seen_reg;
        fwd_next       = fwd_reg;
        yaw_next       = yaw_reg;
        acc_f_next     = acc_f_reg;
        acc_t_next     = acc_t_reg;
        prod_next      = prod_reg;
        fcode_next     = fcode_reg;
        tcode_next     = tcode_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            seen_next  = 1'b1;
            fwd_next   = forward_speed;
            yaw_next   = yaw_rate;
            acc_f_next = FWD_C3;
            acc_t_next = TRN_C3;
        end
        else if (busy_reg)
        begin
            if (ucw.mul_en)
                prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
            if (ucw.add_en)
            begin
                if (ucw.add_lane == LANE_TRN)
                    acc_t_next = add_res;
                else
                    acc_f_next = add_res;
            end

            if (ucw.fin)
            begin
                if (fin_fire)
                begin
                    if (fwd_hi)
                        fcode_next = code_high_reg;
                    else if (fwd_lo)
                        fcode_next = code_low_reg;
                    else if (fwd_zero)
                        fcode_next = fwd_neutral_reg;
                    else
                        fcode_next = fwd_cubic_code;

                    if (trn_hi)
                        tcode_next = code_high_reg;
                    else if (trn_zero)
                        tcode_next = trn_neutral_reg;
                    else
                        tcode_next = trn_cubic_code;

                    out_valid_next = 1'b1;
                    busy_next      = 1'b0;
                end
            end
            else if (ucw.skip_jmp && fwd_fixed && trn_fixed)
                step_next = ucw.jmp_target;
            else
                step_next = step_reg + 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= '0;
            yaw_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            fwd_reg       <= fwd_next;
            yaw_reg       <= yaw_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        acc_f_reg <= acc_f_next;
        acc_t_reg <= acc_t_next;
        prod_reg  <= prod_next;
        fcode_reg <= fcode_next;
        tcode_reg <= tcode_next;
    end

endmodule

// ----- rtl/stj_checker.sv -----
// stj_checker: port-level assertions for speed_to_joystick_code, bound to the top level
// depends on speed_to_joystick_code ports only
module stj_checker #(
    parameter int CODE_WIDTH = 12
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [CODE_WIDTH-1:0] forward_code,
    input logic [CODE_WIDTH-1:0] turn_code
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(forward_code) && $stable(turn_code))
        else $error("result payload changed while stalled");

    // a fresh result only appears as the sequencer finishes
    a_result_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $fell(in_stall))
        else $error("result without sequencer finishing");

    // the sequencer only starts on an input beat
    a_busy_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("sequencer started without input beat");

endmodule

bind speed_to_joystick_code stj_checker #(.CODE_WIDTH(CODE_WIDTH)) u_stj_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .forward_code (forward_code),
    .turn_code    (turn_code)
);
